// ===== sv/ffca_pkg.sv =====
`default_nettype none
package ffca_pkg;

	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 24;

	localparam int REQ_W  = 12;
	localparam int OFFS_W = 13;
	localparam int BSZ_W  = 13;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_SPACE    = 2'd1,
		ST_BAD_ADDRESS = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef struct packed {
		logic              mode;
		logic [REQ_W-1:0]  request_size;
		logic [OFFS_W-1:0] payload_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [OFFS_W-1:0] result_offset;
		logic [BSZ_W-1:0]  block_size;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_ALLOC_FIX,
		S_ALLOC_HEAD,
		S_FREE_RD,
		S_FREE_CHK,
		S_FREE_NXT,
		S_FREE_NFIX,
		S_FREE_PREV,
		S_FREE_PCHK,
		S_FREE_PFIX,
		S_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== sv/ffca_stream_if.sv =====
`default_nettype none
interface ffca_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ffca_hdr_mem.sv =====
`default_nettype none
module ffca_hdr_mem #(
	parameter int AW = 12,
	parameter int DW = 26,
	parameter logic [DW-1:0] RST_WORD = '0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rd_s1;
	logic          zero_s1;
	logic          e0_written_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1   <= mem[raddr];
		zero_s1 <= (raddr == '0);
	end

	// entry zero holds the whole-arena block until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_written_q <= 1'b0;
		end else if (we && waddr == '0) begin
			e0_written_q <= 1'b1;
		end
	end

	assign rdata = (zero_s1 && !e0_written_q) ? RST_WORD : rd_s1;

endmodule
`default_nettype wire

// ===== sv/first_fit_coalescing_allocator_unit.sv =====
// First-fit allocator over one arena of ARENA_BYTES with in-band headers of
// HEADER_BYTES. mode 0 allocates request_size bytes and returns the payload
// offset; mode 1 frees the block whose payload starts at payload_offset and
// merges it with free neighbors. One transaction is handled at a time. The
// headers live in a single memory with one read and one write port and a
// registered read, so the walk visits each block header in a read state and
// a check state. The result sits in an output register until taken. No
// clearing pass is needed after reset.
`default_nettype none
module first_fit_coalescing_allocator_unit #(
	parameter int ARENA_BYTES  = ffca_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ffca_stream_if.sink   req,
	ffca_stream_if.source rsp
);

	localparam int OFF_W  = $clog2(ARENA_BYTES);
	localparam int SIZE_W = OFF_W + 1;
	localparam int SUM_W  = OFF_W + 2;
	localparam int CW     = (SUM_W > 14) ? SUM_W : 14;
	localparam int DW     = 1 + SIZE_W + OFF_W;

	localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
	localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
	localparam logic [DW-1:0] RST_WORD = {1'b1, SIZE_W'(ARENA_BYTES), OFF_W'(0)};

	typedef struct packed {
		logic              free;
		logic [SIZE_W-1:0] size;
		logic [OFF_W-1:0]  prev;
	} hdr_t;

	ffca_pkg::state_t state_q, state_d;

	logic [CW-1:0]     req_q, req_d;
	logic [CW-1:0]     target_q, target_d;
	logic [ffca_pkg::OFFS_W-1:0] poff_q, poff_d;
	logic [CW-1:0]     o_q, o_d;
	logic [CW-1:0]     n_q, n_d;
	logic [CW-1:0]     a_q, a_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [OFF_W-1:0]  prev_q, prev_d;
	ffca_pkg::rsp_t    res_q, res_d;
	ffca_pkg::rsp_t    out_q;
	logic              out_valid_q;

	logic             we;
	logic [OFF_W-1:0] waddr;
	hdr_t             wdata;
	logic [OFF_W-1:0] raddr;
	hdr_t             rd;
	logic [DW-1:0]    rd_raw;

	logic [CW-1:0] rd_size_c;
	logic [CW-1:0] sz_c;
	logic [CW-1:0] nx;
	logic [CW-1:0] af;

	ffca_hdr_mem #(
		.AW       (OFF_W),
		.DW       (DW),
		.RST_WORD (RST_WORD)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rd_raw)
	);

	assign rd        = hdr_t'(rd_raw);
	assign rd_size_c = CW'(rd.size);

	assign req.ready = (state_q == ffca_pkg::S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffca_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		target_q <= target_d;
		poff_q   <= poff_d;
		o_q      <= o_d;
		n_q      <= n_d;
		a_q      <= a_d;
		size_q   <= size_d;
		prev_q   <= prev_d;
		res_q    <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ffca_pkg::S_EMIT && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ffca_pkg::S_EMIT && (!out_valid_q || rsp.ready)) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		req_d    = req_q;
		target_d = target_q;
		poff_d   = poff_q;
		o_d      = o_q;
		n_d      = n_q;
		a_d      = a_q;
		size_d   = size_q;
		prev_d   = prev_q;
		res_d    = res_q;
		we       = 1'b0;
		waddr    = o_q[OFF_W-1:0];
		wdata    = '0;
		raddr    = o_q[OFF_W-1:0];
		sz_c     = '0;
		nx       = '0;
		af       = '0;

		unique case (state_q)
			ffca_pkg::S_IDLE: begin
				if (req.valid) begin
					o_d    = '0;
					poff_d = req.data.payload_offset;
					req_d  = CW'(req.data.request_size);
					if (req.data.mode == ffca_pkg::MODE_ALLOC) begin
						state_d = ffca_pkg::S_ALLOC_RD;
					end else if (CW'(req.data.payload_offset) < HDR_C) begin
						res_d   = '{ffca_pkg::ST_BAD_ADDRESS, req.data.payload_offset, '0};
						state_d = ffca_pkg::S_EMIT;
					end else begin
						target_d = CW'(req.data.payload_offset) - HDR_C;
						state_d  = ffca_pkg::S_FREE_RD;
					end
				end
			end

			ffca_pkg::S_ALLOC_RD: begin
				if (o_q >= ARENA_C) begin
					res_d   = '{ffca_pkg::ST_NO_SPACE, '0, '0};
					state_d = ffca_pkg::S_EMIT;
				end else begin
					state_d = ffca_pkg::S_ALLOC_CHK;
				end
			end

			ffca_pkg::S_ALLOC_CHK: begin
				if (rd.free && rd_size_c >= req_q + HDR_C) begin
					prev_d = rd.prev;
					if (rd_size_c >= req_q + HDR_C + HDR_C) begin
						// split: new free block after the request, fix its successor
						nx     = o_q + HDR_C + req_q;
						af     = o_q + HDR_C + rd_size_c;
						n_d    = nx;
						a_d    = af;
						size_d = SIZE_W'(req_q);
						if (nx < ARENA_C) begin
							we    = 1'b1;
							waddr = nx[OFF_W-1:0];
							wdata = '{1'b1, SIZE_W'(rd_size_c - req_q - HDR_C),
								o_q[OFF_W-1:0]};
						end
						raddr   = af[OFF_W-1:0];
						state_d = ffca_pkg::S_ALLOC_FIX;
					end else begin
						we      = 1'b1;
						wdata   = '{1'b0, rd.size, rd.prev};
						res_d   = '{ffca_pkg::ST_OK, ffca_pkg::OFFS_W'(o_q + HDR_C),
							ffca_pkg::BSZ_W'(rd.size)};
						state_d = ffca_pkg::S_EMIT;
					end
				end else begin
					nx      = o_q + HDR_C + rd_size_c;
					o_d     = nx;
					raddr   = nx[OFF_W-1:0];
					state_d = ffca_pkg::S_ALLOC_RD;
				end
			end

			ffca_pkg::S_ALLOC_FIX: begin
				if (a_q < ARENA_C) begin
					we    = 1'b1;
					waddr = a_q[OFF_W-1:0];
					wdata = '{rd.free, rd.size, n_q[OFF_W-1:0]};
				end
				state_d = ffca_pkg::S_ALLOC_HEAD;
			end

			ffca_pkg::S_ALLOC_HEAD: begin
				we      = 1'b1;
				wdata   = '{1'b0, size_q, prev_q};
				res_d   = '{ffca_pkg::ST_OK, ffca_pkg::OFFS_W'(o_q + HDR_C),
					ffca_pkg::BSZ_W'(size_q)};
				state_d = ffca_pkg::S_EMIT;
			end

			ffca_pkg::S_FREE_RD: begin
				if (o_q >= ARENA_C || o_q > target_q) begin
					res_d   = '{ffca_pkg::ST_BAD_ADDRESS, poff_q, '0};
					state_d = ffca_pkg::S_EMIT;
				end else begin
					state_d = ffca_pkg::S_FREE_CHK;
				end
			end

			ffca_pkg::S_FREE_CHK: begin
				nx = o_q + HDR_C + rd_size_c;
				if (o_q == target_q) begin
					if (rd.free) begin
						res_d   = '{ffca_pkg::ST_BAD_ADDRESS, poff_q, '0};
						state_d = ffca_pkg::S_EMIT;
					end else begin
						prev_d  = rd.prev;
						size_d  = rd.size;
						n_d     = nx;
						raddr   = nx[OFF_W-1:0];
						state_d = ffca_pkg::S_FREE_NXT;
					end
				end else begin
					o_d     = nx;
					raddr   = nx[OFF_W-1:0];
					state_d = ffca_pkg::S_FREE_RD;
				end
			end

			ffca_pkg::S_FREE_NXT: begin
				if (n_q < ARENA_C && rd.free) begin
					sz_c    = CW'(size_q) + HDR_C + rd_size_c;
					af      = o_q + HDR_C + sz_c;
					size_d  = SIZE_W'(sz_c);
					a_d     = af;
					raddr   = af[OFF_W-1:0];
					state_d = ffca_pkg::S_FREE_NFIX;
				end else begin
					state_d = ffca_pkg::S_FREE_PREV;
				end
			end

			ffca_pkg::S_FREE_NFIX: begin
				if (a_q < ARENA_C) begin
					we    = 1'b1;
					waddr = a_q[OFF_W-1:0];
					wdata = '{rd.free, rd.size, o_q[OFF_W-1:0]};
				end
				state_d = ffca_pkg::S_FREE_PREV;
			end

			ffca_pkg::S_FREE_PREV: begin
				if (o_q != '0) begin
					raddr   = prev_q;
					state_d = ffca_pkg::S_FREE_PCHK;
				end else begin
					we      = 1'b1;
					wdata   = '{1'b1, size_q, prev_q};
					res_d   = '{ffca_pkg::ST_OK, poff_q, ffca_pkg::BSZ_W'(size_q)};
					state_d = ffca_pkg::S_EMIT;
				end
			end

			ffca_pkg::S_FREE_PCHK: begin
				if (rd.free) begin
					sz_c    = rd_size_c + HDR_C + CW'(size_q);
					af      = CW'(prev_q) + HDR_C + sz_c;
					we      = 1'b1;
					waddr   = prev_q;
					wdata   = '{1'b1, SIZE_W'(sz_c), rd.prev};
					size_d  = SIZE_W'(sz_c);
					a_d     = af;
					raddr   = af[OFF_W-1:0];
					state_d = ffca_pkg::S_FREE_PFIX;
				end else begin
					we      = 1'b1;
					wdata   = '{1'b1, size_q, prev_q};
					res_d   = '{ffca_pkg::ST_OK, poff_q, ffca_pkg::BSZ_W'(size_q)};
					state_d = ffca_pkg::S_EMIT;
				end
			end

			ffca_pkg::S_FREE_PFIX: begin
				if (a_q < ARENA_C) begin
					we    = 1'b1;
					waddr = a_q[OFF_W-1:0];
					wdata = '{rd.free, rd.size, prev_q};
				end
				res_d   = '{ffca_pkg::ST_OK, poff_q, ffca_pkg::BSZ_W'(size_q)};
				state_d = ffca_pkg::S_EMIT;
			end

			ffca_pkg::S_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ffca_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = ffca_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire
